>>> design/assert_macros.svh
// Assertion macros shared by the header parser RTL.
// Each macro takes a label, the clock, the active-low reset, and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> design/lha_pkg.sv
// Shared types and constants for the LHA level 0/1 header parser.
// Used by lha_out_skid and lha_level01_header_parser_core; no dependencies.
package lha_pkg;

	localparam int POS_W      = 9;    // byte position reaches at most 256
	localparam int TDATA_IN_W = 8;
	localparam int TDATA_OUT_W = 176; // 169 field bits padded to whole bytes
	localparam int TUSER_OUT_W = 3;
	localparam int PADDR_W    = 3;

	localparam logic [7:0] MIN_LEN_L0 = 8'd22;
	localparam logic [7:0] MIN_LEN_L1 = 8'd25;
	localparam logic [7:0] LEVEL_MAX  = 8'd1;

	localparam logic [PADDR_W-1:0] ADDR_UNKNOWN_OS = 3'd0;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MAIN,
		PH_EXT
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_LEVEL  = 3'd1,
		ST_TOO_SHORT  = 3'd2,
		ST_BAD_SUM    = 3'd3,
		ST_PATH_LONG  = 3'd4,
		ST_EXT_SHORT  = 3'd5
	} status_t;

	typedef struct packed {
		status_t       status;
		logic          level;
		logic [39:0]   method_id;
		logic [31:0]   packed_size;
		logic [31:0]   original_size;
		logic [31:0]   dos_timestamp;
		logic [7:0]    path_length;
		logic [7:0]    os_kind;
		logic [15:0]   file_crc;
	} res_t;

endpackage

>>> design/lha_out_skid.sv
// Two-entry result buffer: an output register and a skid register behind it.
// Depends on lha_pkg for the result record type.
`include "assert_macros.svh"

module lha_out_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  lha_pkg::res_t in_res,
	output logic          up_ready,
	output logic          out_valid,
	output lha_pkg::res_t out_res,
	input  logic          out_ready
);
	import lha_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_res_q;
	res_t skid_res_q;
	logic load_out;

	// The output register can take a new beat when it is empty or draining.
	assign load_out = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_res_q <= skid_valid_q ? skid_res_q : in_res;
		end else if (in_valid) begin
			skid_res_q <= in_res;
		end
	end

	assign up_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`ASSERT_IMPLIES(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`ASSERT_IMPLIES(a_no_push_when_full, clk, arst_n, in_valid, !skid_valid_q)
	`ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && out_ready,
		out_valid_q && !skid_valid_q)

endmodule

>>> design/lha_level01_header_parser_core.sv
// Top level of the LHA level 0/1 header parser: stream ports, APB register, parser state.
// Depends on lha_pkg, lha_out_skid and assert_macros.svh.
//
// Usage: archive bytes enter on the s_axis channel, one byte per beat, with
// tuser set on byte 0 of each header. Any beat with tuser set restarts the
// parser and drops a header in progress without a result. The parser gives
// one m_axis beat per header: tuser carries the status code, tdata the fields
// (all zero for an error). After a result, bytes are ignored until the next
// start beat. Level 1 extended headers are skipped by their next-size chain.
// Throughput is one byte per cycle; every byte is handled by combinational
// logic between the parser state registers and the result buffer.
// The result is formed from the byte that ends the header (last base header
// byte, or last extended header byte) and registered in the result buffer.
// When the receiver stalls, one result waits in the output register and a
// second in a skid register; s_axis_tready drops only while the skid is full.
// Reset puts the parser idle, empties the result buffer and clears
// unknown_os_code (APB byte address 0) to zero. Write it only while idle.

`include "assert_macros.svh"

module lha_level01_header_parser_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lha_pkg::PADDR_W-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// Byte stream in
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [lha_pkg::TDATA_IN_W-1:0]    s_axis_tdata,  // [7:0] data_byte
	input  logic                              s_axis_tuser,  // [0] start_of_header
	// Header results out
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] level, [40:1] method_id, [72:41] packed_size, [104:73] original_size,
	// [136:105] dos_timestamp, [144:137] path_length, [152:145] os_kind,
	// [168:153] file_crc, [175:169] zero
	output logic [lha_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
	output logic [lha_pkg::TUSER_OUT_W-1:0]   m_axis_tuser   // [2:0] status
);
	import lha_pkg::*;

	logic [7:0] unknown_os_q;

	phase_t          phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]      len_q, len_d;
	logic [7:0]      exp_q, exp_d;
	logic [7:0]      sum_q, sum_d;
	logic            level_q, level_d;
	logic [7:0]      path_q, path_d;
	logic [39:0]     method_q, method_d;
	logic [31:0]     packed_q, packed_d;
	logic [31:0]     orig_q, orig_d;
	logic [31:0]     time_q, time_d;
	logic [7:0]      os_q, os_d;
	logic [15:0]     crc_q, crc_d;
	logic [15:0]     ext_q, ext_d;
	logic [15:0]     ltb_q, ltb_d;

	logic        accept;
	logic [7:0]  b;
	logic        res_valid;
	logic        res_ok;
	status_t     res_status;
	logic        chain;
	logic [7:0]  minlen;
	logic [9:0]  pos_w;
	logic [9:0]  crc_lo_pos;
	res_t        res;
	res_t        out_res;
	logic        out_valid;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign b      = s_axis_tdata;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unknown_os_q <= 8'd0;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_UNKNOWN_OS) begin
			unknown_os_q <= pwdata[7:0];
		end
	end
	assign prdata = (paddr == ADDR_UNKNOWN_OS) ? {24'd0, unknown_os_q} : 32'd0;

	assign pos_w      = {1'b0, pos_q};
	assign crc_lo_pos = 10'd22 + {2'd0, path_q};
	assign minlen     = level_q ? MIN_LEN_L1 : MIN_LEN_L0;

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		len_d      = len_q;
		exp_d      = exp_q;
		sum_d      = sum_q;
		level_d    = level_q;
		path_d     = path_q;
		method_d   = method_q;
		packed_d   = packed_q;
		orig_d     = orig_q;
		time_d     = time_q;
		os_d       = os_q;
		crc_d      = crc_q;
		ext_d      = ext_q;
		ltb_d      = ltb_q;
		res_valid  = 1'b0;
		res_ok     = 1'b0;
		res_status = ST_OK;
		chain      = 1'b0;

		if (accept) begin
			if (s_axis_tuser) begin
				phase_d = PH_MAIN;
				pos_d   = 9'd1;
				len_d   = b;
				sum_d   = 8'd0;
				level_d = 1'b0;
				path_d  = 8'd0;
				ltb_d   = 16'd0;
			end else if (phase_q == PH_EXT) begin
				ltb_d = {b, ltb_q[15:8]};
				ext_d = ext_q - 16'd1;
				if (ext_q == 16'd1) begin
					chain = 1'b1;
				end
			end else if (phase_q == PH_MAIN) begin
				if (pos_q == 9'd1) begin
					exp_d = b;
				end else begin
					sum_d = sum_q + b;
				end
				ltb_d = {b, ltb_q[15:8]};
				pos_d = pos_q + 9'd1;

				case (pos_q) inside
					[9'd2:9'd6]: method_d = {method_q[31:0], b};
					9'd7:  packed_d[7:0]   = b;
					9'd8:  packed_d[15:8]  = b;
					9'd9:  packed_d[23:16] = b;
					9'd10: packed_d[31:24] = b;
					9'd11: orig_d[7:0]     = b;
					9'd12: orig_d[15:8]    = b;
					9'd13: orig_d[23:16]   = b;
					9'd14: orig_d[31:24]   = b;
					9'd15: time_d[7:0]     = b;
					9'd16: time_d[15:8]    = b;
					9'd17: time_d[23:16]   = b;
					9'd18: time_d[31:24]   = b;
					9'd20: begin
						if (b > LEVEL_MAX) begin
							res_valid  = 1'b1;
							res_status = ST_BAD_LEVEL;
						end else begin
							level_d = b[0];
							if (len_q < (b[0] ? MIN_LEN_L1 : MIN_LEN_L0)) begin
								res_valid  = 1'b1;
								res_status = ST_TOO_SHORT;
							end
						end
					end
					9'd21: path_d = b;
					[9'd22:9'd511]: begin
						if (pos_w == crc_lo_pos) begin
							crc_d[7:0] = b;
						end else if (pos_w == crc_lo_pos + 10'd1) begin
							crc_d[15:8] = b;
						end else if (level_q && pos_w == crc_lo_pos + 10'd2) begin
							os_d = b;
						end
					end
					default: ;
				endcase

				// End of the base header: byte H+1, where H is the length byte.
				if (pos_q > 9'd20 && pos_q == {1'b0, len_q} + 9'd1) begin
					if (sum_d != exp_q) begin
						res_valid  = 1'b1;
						res_status = ST_BAD_SUM;
					end else if ({1'b0, minlen} + {1'b0, path_q} > {1'b0, len_q}) begin
						res_valid  = 1'b1;
						res_status = ST_PATH_LONG;
					end else if (!level_q) begin
						res_valid = 1'b1;
						res_ok    = 1'b1;
					end else begin
						chain = 1'b1;
					end
				end
			end
		end

		// Follow the extended header chain using the last two bytes seen.
		if (chain) begin
			if (ltb_d == 16'd0) begin
				res_valid = 1'b1;
				res_ok    = 1'b1;
			end else begin
				packed_d = packed_d - {16'd0, ltb_d};
				if (ltb_d < 16'd3) begin
					res_valid  = 1'b1;
					res_status = ST_EXT_SHORT;
				end else begin
					ext_d   = ltb_d;
					phase_d = PH_EXT;
				end
			end
		end

		if (res_valid) begin
			phase_d = PH_IDLE;
		end
	end

	always_comb begin
		res = '0;
		res.status = res_status;
		if (res_ok) begin
			res.level         = level_d;
			res.method_id     = method_d;
			res.packed_size   = packed_d;
			res.original_size = orig_d;
			res.dos_timestamp = time_d;
			res.path_length   = path_d;
			res.os_kind       = level_d ? os_d : unknown_os_q;
			res.file_crc      = crc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			len_q   <= 8'd0;
			exp_q   <= 8'd0;
			sum_q   <= 8'd0;
			level_q <= 1'b0;
			path_q  <= 8'd0;
			ext_q   <= 16'd0;
			ltb_q   <= 16'd0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			exp_q   <= exp_d;
			sum_q   <= sum_d;
			level_q <= level_d;
			path_q  <= path_d;
			ext_q   <= ext_d;
			ltb_q   <= ltb_d;
		end
	end

	// Field registers are fully rewritten before any successful result uses them.
	always_ff @(posedge clk) begin
		method_q <= method_d;
		packed_q <= packed_d;
		orig_q   <= orig_d;
		time_q   <= time_d;
		os_q     <= os_d;
		crc_q    <= crc_d;
	end

	lha_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.up_ready  (s_axis_tready),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tuser  = out_res.status;
	assign m_axis_tdata  = {7'd0, out_res.file_crc, out_res.os_kind, out_res.path_length,
		out_res.dos_timestamp, out_res.original_size, out_res.packed_size,
		out_res.method_id, out_res.level};

	`ASSERT_NEXT(a_idle_after_result, clk, arst_n, res_valid, phase_q == PH_IDLE)
	`ASSERT_IMPLIES(a_ext_only_level1, clk, arst_n, phase_q == PH_EXT, level_q)

endmodule

>>> verif/tb_lha_level01_header_parser_core.sv
// Self-checking testbench for lha_level01_header_parser_core: level 0/1 archive
// header parsing, extended header chains, error codes and the unknown-OS register.
// Depends on lha_pkg and the parser RTL; a built-in parser model predicts each result.
`timescale 1ns / 100ps

module tb_lha_level01_header_parser_core;
	import lha_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE      = 4;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [PADDR_W-1:0]       paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [TDATA_IN_W-1:0]    s_axis_tdata;  // [7:0] data_byte
	logic                     s_axis_tuser;  // [0] start_of_header
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	// [0] level, [40:1] method_id, [72:41] packed_size, [104:73] original_size,
	// [136:105] dos_timestamp, [144:137] path_length, [152:145] os_kind,
	// [168:153] file_crc, [175:169] zero
	logic [TDATA_OUT_W-1:0]   m_axis_tdata;
	logic [TUSER_OUT_W-1:0]   m_axis_tuser;  // [2:0] status

	lha_level01_header_parser_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Parser model state.
	phase_t       ph;
	logic [15:0]  pos;
	logic [7:0]   hlen;
	logic [7:0]   sum_exp;
	logic [7:0]   sum_run;
	logic         lvl_r;
	logic [7:0]   plen_r;
	logic [39:0]  meth_r;
	logic [31:0]  pk_r;
	logic [31:0]  orig_r;
	logic [31:0]  time_r;
	logic [7:0]   os_r;
	logic [15:0]  crc_r;
	logic [15:0]  ext_left;
	logic [15:0]  tail2;
	logic [7:0]   os_code;

	res_t         pending_hdrs[$];
	int           hdrs_predicted;
	int           errs;

	// Stimulus controls.
	bit           tx_up;
	bit           tx_gaps;
	bit           rx_stalls;
	bit           hold_req;
	bit           zero_packed;
	int           cut_at;
	int           ext_chain[$];
	logic [7:0]   hbuf [0:256];
	logic [7:0]   hdr_q[$];

	function automatic void clear_parse();
		ph = PH_IDLE;
		pos = '0;
		hlen = '0;
		sum_exp = '0;
		sum_run = '0;
		lvl_r = 1'b0;
		plen_r = '0;
		meth_r = '0;
		pk_r = '0;
		orig_r = '0;
		time_r = '0;
		os_r = '0;
		crc_r = '0;
		ext_left = '0;
		tail2 = '0;
	endfunction

	function automatic void post_error(input status_t code);
		res_t r;
		r = '0;
		r.status = code;
		pending_hdrs.push_back(r);
		hdrs_predicted++;
		ph = PH_IDLE;
	endfunction

	function automatic void post_ok();
		res_t r;
		r.status = ST_OK;
		r.level = lvl_r;
		r.method_id = meth_r;
		r.packed_size = pk_r;
		r.original_size = orig_r;
		r.dos_timestamp = time_r;
		r.path_length = plen_r;
		r.os_kind = lvl_r ? os_r : os_code;
		r.file_crc = crc_r;
		pending_hdrs.push_back(r);
		hdrs_predicted++;
		ph = PH_IDLE;
	endfunction

	// The last two bytes seen hold the size of the next extended header.
	function automatic void follow_chain();
		logic [15:0] sz;
		sz = tail2;
		if (sz == 16'd0) begin
			post_ok();
			return;
		end
		pk_r = pk_r - 32'(sz);
		if (sz < 16'd3) begin
			post_error(ST_EXT_SHORT);
			return;
		end
		ext_left = sz;
		ph = PH_EXT;
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic sof);
		int p;
		int pl;
		int minl;
		if (sof) begin
			clear_parse();
			hlen = b;
			pos = 16'd1;
			ph = PH_MAIN;
			return;
		end
		if (ph == PH_EXT) begin
			tail2 = {b, tail2[15:8]};
			ext_left = ext_left - 16'd1;
			if (ext_left == 16'd0)
				follow_chain();
			return;
		end
		if (ph != PH_MAIN)
			return;

		p = int'(pos);
		pl = int'(plen_r);
		if (p == 1)
			sum_exp = b;
		else
			sum_run = sum_run + b;
		tail2 = {b, tail2[15:8]};

		if (p >= 2 && p <= 6)
			meth_r = {meth_r[31:0], b};
		else if (p >= 7 && p <= 10)
			pk_r = pk_r | (32'(b) << (8 * (p - 7)));
		else if (p >= 11 && p <= 14)
			orig_r = orig_r | (32'(b) << (8 * (p - 11)));
		else if (p >= 15 && p <= 18)
			time_r = time_r | (32'(b) << (8 * (p - 15)));
		else if (p == 20) begin
			// Level is checked before the minimum length.
			if (b > LEVEL_MAX) begin
				post_error(ST_BAD_LEVEL);
				return;
			end
			lvl_r = b[0];
			minl = lvl_r ? int'(MIN_LEN_L1) : int'(MIN_LEN_L0);
			if (int'(hlen) < minl) begin
				post_error(ST_TOO_SHORT);
				return;
			end
		end else if (p == 21)
			plen_r = b;
		else if (p >= 22) begin
			if (p == 22 + pl)
				crc_r[7:0] = b;
			else if (p == 23 + pl)
				crc_r[15:8] = b;
			else if (lvl_r && p == 24 + pl)
				os_r = b;
		end

		if (p > 20 && p == int'(hlen) + 1) begin
			minl = lvl_r ? int'(MIN_LEN_L1) : int'(MIN_LEN_L0);
			if (sum_run != sum_exp) begin
				post_error(ST_BAD_SUM);
				return;
			end
			if (minl + pl > int'(hlen)) begin
				post_error(ST_PATH_LONG);
				return;
			end
			if (!lvl_r) begin
				post_ok();
				return;
			end
			follow_chain();
			return;
		end
		pos = 16'(p + 1);
	endfunction

	function automatic int idle_len();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(5, 40);
	endfunction

	function automatic void cmp_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_hdrs.size() == 0) begin
				$error("result beat with no header pending, status %0d", m_axis_tuser);
				errs++;
			end else begin
				want = pending_hdrs.pop_front();
				cmp_field("status", 64'(want.status), 64'(m_axis_tuser));
				cmp_field("level", 64'(want.level), 64'(m_axis_tdata[0]));
				cmp_field("method_id", 64'(want.method_id), 64'(m_axis_tdata[40:1]));
				cmp_field("packed_size", 64'(want.packed_size), 64'(m_axis_tdata[72:41]));
				cmp_field("original_size", 64'(want.original_size),
					64'(m_axis_tdata[104:73]));
				cmp_field("dos_timestamp", 64'(want.dos_timestamp),
					64'(m_axis_tdata[136:105]));
				cmp_field("path_length", 64'(want.path_length), 64'(m_axis_tdata[144:137]));
				cmp_field("os_kind", 64'(want.os_kind), 64'(m_axis_tdata[152:145]));
				cmp_field("file_crc", 64'(want.file_crc), 64'(m_axis_tdata[168:153]));
			end
		end
	end

	// Result receiver: random stalls, plus a long hold-off on request.
	initial begin : result_sink
		int n;
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				n = idle_len();
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				n = idle_len();
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		#2000000;
		$display("tb_lha_level01_header_parser_core: FAIL");
		$finish;
	end

	// Offers one byte and waits for its beat; tvalid stays up when no gap follows.
	task automatic send_byte(input logic [7:0] b, input logic sof);
		int g;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= sof;
		tx_up = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		parse_byte(b, sof);
		if (tx_gaps && $urandom_range(0, 2) == 0) begin
			g = idle_len();
			s_axis_tvalid <= 1'b0;
			tx_up = 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic tx_idle();
		if (tx_up) begin
			s_axis_tvalid <= 1'b0;
			tx_up = 1'b0;
		end
	endtask

	task automatic drain();
		tx_idle();
		while (pending_hdrs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_os_code(input logic [7:0] v);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_UNKNOWN_OS;
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		os_code = v;
	endtask

	// Builds a header with random content around the given length, level and path
	// length, then any level 1 extended headers listed in ext_chain, and sends it.
	task automatic send_header(input logic [7:0] hl, input logic [7:0] lvl,
			input logic [7:0] plen, input bit bad_sum);
		int n;
		int lim;
		int i;
		logic [7:0] s;
		logic [15:0] nx;
		n = (int'(hl) + 2 > 21) ? int'(hl) + 2 : 21;
		for (i = 0; i < n; i++)
			hbuf[i] = 8'($urandom);
		hbuf[0] = hl;
		hbuf[20] = lvl;
		if (n > 21)
			hbuf[21] = plen;
		if (zero_packed)
			for (i = 7; i <= 10; i++)
				hbuf[i] = 8'h00;
		nx = (ext_chain.size() != 0) ? 16'(ext_chain[0]) : 16'd0;
		if (lvl == 8'd1 && hl >= 8'd22) begin
			hbuf[hl] = nx[7:0];
			hbuf[int'(hl) + 1] = nx[15:8];
		end
		s = 8'd0;
		for (i = 2; i <= int'(hl) + 1; i++)
			s = s + hbuf[i];
		hbuf[1] = bad_sum ? s + 8'($urandom_range(1, 255)) : s;

		hdr_q.delete();
		for (i = 0; i < n; i++)
			hdr_q.push_back(hbuf[i]);
		if (lvl == 8'd1) begin
			for (i = 0; i < ext_chain.size() && ext_chain[i] >= 3; i++) begin
				nx = (i + 1 < ext_chain.size()) ? 16'(ext_chain[i + 1]) : 16'd0;
				repeat (ext_chain[i] - 2) hdr_q.push_back(8'($urandom));
				hdr_q.push_back(nx[7:0]);
				hdr_q.push_back(nx[15:8]);
			end
		end
		lim = (cut_at > 0 && cut_at < hdr_q.size()) ? cut_at : hdr_q.size();
		for (i = 0; i < lim; i++)
			send_byte(hdr_q[i], i == 0);
		ext_chain.delete();
		cut_at = 0;
		zero_packed = 1'b0;
	endtask

	task automatic test_level0();
		repeat (3) send_byte(8'($urandom), 1'b0);   // idle after reset: ignored
		send_header(8'd22, 8'd0, 8'd0, 1'b0);
		send_header(8'd30, 8'd0, 8'd5, 1'b0);
		send_header(8'd255, 8'd0, 8'd233, 1'b0);
		send_header(8'd255, 8'd0, 8'd255, 1'b0);
		send_header(8'd25, 8'd0, 8'd4, 1'b0);
	endtask

	task automatic test_level1();
		send_header(8'd25, 8'd1, 8'd0, 1'b0);
		ext_chain = '{5, 3};
		send_header(8'd28, 8'd1, 8'd2, 1'b0);
		ext_chain = '{600};
		send_header(8'd26, 8'd1, 8'd1, 1'b0);
		// Packed size of zero wraps once the extended sizes come off.
		zero_packed = 1'b1;
		ext_chain = '{4, 7};
		send_header(8'd27, 8'd1, 8'd0, 1'b0);
		ext_chain = '{1};
		send_header(8'd25, 8'd1, 8'd0, 1'b0);
		ext_chain = '{6, 2};
		send_header(8'd30, 8'd1, 8'd3, 1'b0);
		send_header(8'd255, 8'd1, 8'd230, 1'b0);
	endtask

	task automatic test_errors();
		send_header(8'd22, 8'd2, 8'd0, 1'b0);
		send_header(8'd40, 8'd255, 8'd3, 1'b0);
		send_header(8'd3, 8'd7, 8'd0, 1'b0);      // level wins over length
		send_header(8'd21, 8'd0, 8'd0, 1'b0);
		send_header(8'd0, 8'd0, 8'd0, 1'b0);
		send_header(8'd24, 8'd1, 8'd0, 1'b0);
		send_header(8'd30, 8'd0, 8'd2, 1'b1);
		send_header(8'd22, 8'd0, 8'd9, 1'b1);     // checksum wins over path fit
		send_header(8'd25, 8'd1, 8'd1, 1'b1);
	endtask

	task automatic test_restart();
		cut_at = 10;
		send_header(8'd22, 8'd0, 8'd0, 1'b0);
		cut_at = 23;                               // one byte short of the end
		send_header(8'd22, 8'd0, 8'd0, 1'b0);
		ext_chain = '{20};
		cut_at = 35;                               // dropped inside an extension
		send_header(8'd25, 8'd1, 8'd0, 1'b0);
		send_header(8'd23, 8'd0, 8'd1, 1'b0);
		repeat (4) send_byte(8'($urandom), 1'b0);  // after a result: ignored
		send_header(8'd25, 8'd1, 8'd0, 1'b0);
	endtask

	task automatic test_os_code();
		send_header(8'd22, 8'd0, 8'd0, 1'b0);
		set_os_code(8'hff);
		send_header(8'd24, 8'd0, 8'd1, 1'b0);
		send_header(8'd26, 8'd1, 8'd1, 1'b0);
		set_os_code(8'h5a);
		send_header(8'd22, 8'd0, 8'd0, 1'b0);
		set_os_code(8'h00);
		send_header(8'd23, 8'd0, 8'd0, 1'b0);
	endtask

	// The sink holds off while short headers keep coming, so the result buffer
	// fills and s_axis_tready must drop.
	task automatic test_backpressure();
		drain();
		tx_gaps = 1'b0;
		hold_req = 1'b1;
		repeat (8) send_header(8'd22, 8'd2, 8'd0, 1'b0);
		tx_idle();
		while (hold_req)
			@(posedge clk);
		drain();
		tx_gaps = 1'b1;
	endtask

	task automatic rand_header();
		int r;
		int minl;
		int extra;
		int k;
		logic [7:0] lvl;
		logic [7:0] plen;
		logic [7:0] hl;
		r = $urandom_range(0, 99);
		lvl = (r < 45) ? 8'd0 : (r < 90) ? 8'd1 : 8'($urandom_range(2, 255));
		minl = (lvl == 8'd1) ? int'(MIN_LEN_L1) : int'(MIN_LEN_L0);
		plen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255 - minl)) :
			8'($urandom_range(0, 8));
		extra = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3);
		hl = (minl + int'(plen) + extra > 255) ? 8'd255 : 8'(minl + int'(plen) + extra);
		r = $urandom_range(0, 99);
		if (r < 5)
			hl = 8'($urandom_range(0, minl - 1));
		else if (r < 10)
			plen = 8'($urandom_range(int'(hl) - minl + 1, 255));
		if (lvl == 8'd1) begin
			k = $urandom_range(0, 3);
			repeat (k) ext_chain.push_back(($urandom_range(0, 19) == 0) ?
				$urandom_range(13, 300) : $urandom_range(3, 12));
			if ($urandom_range(0, 19) == 0)
				ext_chain.push_back($urandom_range(1, 2));
		end
		if ($urandom_range(0, 19) == 0)
			cut_at = $urandom_range(1, 40);
		send_header(hl, lvl, plen, $urandom_range(0, 11) == 0);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0);
		if ($urandom_range(0, 24) == 0) begin
			send_byte(8'($urandom), 1'b1);
			repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0);
		end
	endtask

	task automatic test_random();
		int phase_no;
		int target;
		for (phase_no = 0; phase_no < 3; phase_no++) begin
			set_os_code(8'($urandom));
			tx_gaps = (phase_no != 1);
			rx_stalls = (phase_no != 2);
			target = hdrs_predicted + 15;
			while (hdrs_predicted < target)
				rand_header();
		end
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
	endtask

	initial begin : run_tests
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		tx_up = 1'b0;
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		hold_req = 1'b0;
		zero_packed = 1'b0;
		cut_at = 0;
		errs = 0;
		hdrs_predicted = 0;
		os_code = 8'h00;
		clear_parse();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_level0();
		test_level1();
		test_errors();
		test_restart();
		test_os_code();
		test_backpressure();
		test_random();

		drain();
		repeat (10) @(posedge clk);
		if (errs == 0 && pending_hdrs.size() == 0)
			$display("tb_lha_level01_header_parser_core: PASS");
		else
			$display("tb_lha_level01_header_parser_core: FAIL");
		$finish;
	end

endmodule
